@@ rtl/core/sle_pkg.sv @@
// Package for the serial line editor: sizes, character codes, sequencer
// states and emission modes. Used by serial_line_editor_with_history_unit.
// Has no dependencies of its own.
package sle_pkg;

  localparam int unsigned LineBytes    = 32;
  localparam int unsigned HistoryDepth = 8;   // must be a power of two
  localparam int unsigned LineAw       = $clog2(LineBytes);
  localparam int unsigned HistAw       = $clog2(HistoryDepth);
  localparam int unsigned FillW        = $clog2(HistoryDepth + 1);

  localparam logic [LineAw-1:0] LineMax = LineAw'(LineBytes - 1);
  localparam logic [FillW-1:0]  FillMax = FillW'(HistoryDepth);

  localparam logic [7:0] ChEsc   = 8'h1b;
  localparam logic [7:0] ChBrack = 8'h5b;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChDel   = 8'h7f;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChGt    = 8'h3e;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChK     = 8'h4b;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] ReqByte    = 2'd0;
  localparam logic [1:0] ReqRead    = 2'd1;
  localparam logic [1:0] ReqRelease = 2'd2;
  localparam logic [1:0] ReqSave    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CfgEcho = 2'd0;
  localparam logic [1:0] CfgUp   = 2'd1;
  localparam logic [1:0] CfgDown = 2'd2;

  // Escape sequence progress.
  localparam logic [1:0] EscIdle  = 2'd0;
  localparam logic [1:0] EscSeen  = 2'd1;
  localparam logic [1:0] EscBrack = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_EMIT   = 7'b0000100,
    S_HFETCH = 7'b0001000,
    S_HPUT   = 7'b0010000,
    S_SFETCH = 7'b0100000,
    S_SWRITE = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    M_NONE,
    M_ECHO,
    M_ECHO_CLR,
    M_PROMPT
  } mode_e;

  // Fixed byte k of an emission, c being the received character.
  function automatic logic [7:0] const_byte(mode_e m, logic [2:0] k, logic [7:0] c);
    logic [7:0] b;
    b = c;
    unique case (m)
      M_ECHO_CLR: begin
        unique case (k)
          3'd1:    b = ChEsc;
          3'd2:    b = ChBrack;
          3'd3:    b = ChK;
          default: b = c;
        endcase
      end
      M_PROMPT: begin
        unique case (k)
          3'd0:    b = ChCr;
          3'd1:    b = ChLf;
          3'd2:    b = ChGt;
          3'd3:    b = ChSpace;
          3'd4:    b = ChEsc;
          3'd5:    b = ChBrack;
          default: b = ChK;
        endcase
      end
      default: b = c;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/serial_line_editor_with_history_unit.sv @@
// Serial line editor with a recall history: line buffer, history memory and
// the byte sequencer. Depends on sle_pkg.
//
// Channel   Dir  Handshake                 Contents
// s_axis    in   s_axis_tvalid/tready      tuser: request kind; tdata: byte, index
// m_axis    out  m_axis_tvalid/tready      tdata: tx byte and status; tlast: end of run
// cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// A received byte or a request is latched in S_IDLE, decoded in S_DECODE and then
// emitted in S_EMIT. A history recall alternates S_HFETCH and S_HPUT per byte and a
// save S_SFETCH and S_SWRITE, as the history and line memories each have a single read port.
// rst_ni clears all control state; the line and history memories are not cleared.
// A stalled output holds the sequencer at its current byte.
module serial_line_editor_with_history_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [12:8] read_index, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] tx_byte, [8] tx_valid, [16:9] read_data,
                                      // [21:17] line_length, [22] line_ready, [23] overflow
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned LAw = sle_pkg::LineAw;
  localparam int unsigned HAw = sle_pkg::HistAw;
  localparam int unsigned FW  = sle_pkg::FillW;

  sle_pkg::state_e state_q, state_d;
  sle_pkg::mode_e  mode_q, mode_d;

  logic           echo_q, echo_d;
  logic [7:0]     up_q, up_d, down_q, down_d;
  logic [1:0]     esc_q, esc_d;
  logic [LAw-1:0] lc_q, lc_d, rlen_q, rlen_d;
  logic           pend_q, pend_d, ovf_q, ovf_d;
  logic [HAw-1:0] head_q, head_d, cur_q, cur_d, slot_q, slot_d;
  logic           curv_q, curv_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [1:0]     req_q, req_d;
  logic [7:0]     ch_q, ch_d, rd_q, rd_d;
  logic [LAw-1:0] idx_q, idx_d, hlen_q, hlen_d, cnt_q, cnt_d;
  logic [2:0]     k_q, k_d;

  logic [LAw-1:0] hlens_q [sle_pkg::HistoryDepth];

  // Output register.
  logic           ov_q, ov_d;
  logic [23:0]    od_q, od_d;
  logic           ol_q, ol_d;

  // Memories.
  logic [7:0] line_mem [sle_pkg::LineBytes];
  logic [7:0] hist_mem [sle_pkg::HistoryDepth * sle_pkg::LineBytes];
  logic [7:0] line_rd_q, hist_rd_q;
  logic [LAw-1:0] line_raddr, line_waddr;
  logic [7:0]     line_wdata, hist_wdata;
  logic           line_we, hist_we, hlen_we;
  logic [HAw+LAw-1:0] hist_raddr, hist_waddr;

  logic           out_free, in_acc, load;
  logic [7:0]     load_byte;
  logic           load_txv, load_last;
  logic           is_del, bslash;
  logic [HAw-1:0] age;
  logic [LAw-1:0] len_sel;

  assign s_axis_tready = (state_q == sle_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;

  assign line_raddr = (state_q == sle_pkg::S_IDLE)
                      ? ((s_axis_tuser == sle_pkg::ReqRead) ? s_axis_tdata[12:8]
                                                             : lc_q - LAw'(1))
                      : cnt_q;
  assign hist_raddr = {slot_q, cnt_q};
  assign hist_waddr = {head_q, cnt_q};
  assign hist_wdata = line_rd_q;

  always_ff @(posedge clk_i) begin
    line_rd_q <= line_mem[line_raddr];
    hist_rd_q <= hist_mem[hist_raddr];
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hlen_we) begin
      hlens_q[head_q] <= rlen_q;
    end
  end

  assign is_del = (ch_q == sle_pkg::ChBs) || (ch_q == sle_pkg::ChDel);
  assign bslash = (lc_q != '0) && (line_rd_q == sle_pkg::ChBslash);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    echo_d  = echo_q;
    up_d    = up_q;
    down_d  = down_q;
    esc_d   = esc_q;
    lc_d    = lc_q;
    rlen_d  = rlen_q;
    pend_d  = pend_q;
    ovf_d   = ovf_q;
    head_d  = head_q;
    cur_d   = cur_q;
    curv_d  = curv_q;
    slot_d  = slot_q;
    fill_d  = fill_q;
    req_d   = req_q;
    ch_d    = ch_q;
    idx_d   = idx_q;
    rd_d    = rd_q;
    hlen_d  = hlen_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    line_we    = 1'b0;
    line_waddr = lc_q;
    line_wdata = ch_q;
    hist_we    = 1'b0;
    hlen_we    = 1'b0;
    load       = 1'b0;
    load_byte  = 8'h00;
    load_txv   = 1'b0;
    load_last  = 1'b0;
    age        = cur_q;
    len_sel    = '0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sle_pkg::CfgEcho: echo_d = cfg_data_i[0];
        sle_pkg::CfgUp:   up_d   = cfg_data_i;
        sle_pkg::CfgDown: down_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      sle_pkg::S_IDLE: begin
        if (in_acc) begin
          req_d   = s_axis_tuser;
          ch_d    = s_axis_tdata[7:0];
          idx_d   = s_axis_tdata[12:8];
          state_d = sle_pkg::S_DECODE;
        end
      end

      sle_pkg::S_DECODE: begin
        mode_d  = sle_pkg::M_NONE;
        k_d     = '0;
        cnt_d   = '0;
        rd_d    = 8'h00;
        state_d = sle_pkg::S_EMIT;
        unique case (req_q)
          sle_pkg::ReqByte: begin
            if (ch_q == sle_pkg::ChEsc) begin
              esc_d = (esc_q == sle_pkg::EscBrack) ? sle_pkg::EscBrack : sle_pkg::EscSeen;
            end else if (ch_q == sle_pkg::ChBrack && esc_q != sle_pkg::EscIdle) begin
              esc_d = sle_pkg::EscBrack;
            end else if (ch_q == up_q && esc_q == sle_pkg::EscBrack) begin
              esc_d = sle_pkg::EscIdle;
              if (curv_q ? ({1'b0, cur_q} + FW'(1) < fill_q) : (fill_q != '0)) begin
                age    = curv_q ? cur_q + HAw'(1) : '0;
                cur_d  = age;
                curv_d = 1'b1;
                mode_d = sle_pkg::M_PROMPT;
              end
            end else if (ch_q == down_q && esc_q == sle_pkg::EscBrack) begin
              esc_d = sle_pkg::EscIdle;
              if (curv_q && cur_q != '0) begin
                age    = cur_q - HAw'(1);
                cur_d  = age;
                mode_d = sle_pkg::M_PROMPT;
              end else if (curv_q) begin
                // Stepping below the newest entry clears the line.
                curv_d = 1'b0;
                mode_d = sle_pkg::M_PROMPT;
              end
            end else if (esc_q == sle_pkg::EscBrack) begin
              esc_d = sle_pkg::EscIdle;
            end else begin
              esc_d = sle_pkg::EscIdle;
              if (echo_q && !(lc_q == '0 && is_del)) begin
                mode_d = sle_pkg::M_ECHO;
              end
              if (pend_q) begin
                ovf_d = 1'b1;
              end else if (is_del) begin
                if (lc_q != '0) begin
                  lc_d = lc_q - LAw'(1);
                  if (echo_q) begin
                    mode_d = sle_pkg::M_ECHO_CLR;
                  end
                end
              end else if ((ch_q == sle_pkg::ChCr && !bslash) || lc_q == sle_pkg::LineMax) begin
                rlen_d = lc_q;
                lc_d   = '0;
                curv_d = 1'b0;
                pend_d = 1'b1;
              end else begin
                line_we = 1'b1;
                lc_d    = lc_q + LAw'(1);
              end
            end
            // A recall or a clear sets the line and, if pending, its length.
            if (mode_d == sle_pkg::M_PROMPT) begin
              slot_d  = head_q - HAw'(1) - age;
              len_sel = curv_d ? hlens_q[head_q - HAw'(1) - age] : '0;
              hlen_d  = len_sel;
              lc_d    = len_sel;
              if (pend_q) begin
                rlen_d = len_sel;
              end
            end
          end
          sle_pkg::ReqRead: begin
            if (pend_q && idx_q < rlen_q) begin
              rd_d = line_rd_q;
            end
          end
          sle_pkg::ReqRelease: begin
            pend_d = 1'b0;
            ovf_d  = 1'b0;
          end
          default: begin
            if (pend_q) begin
              if (rlen_q == '0) begin
                hlen_we = 1'b1;
                head_d  = head_q + HAw'(1);
                if (fill_q != sle_pkg::FillMax) begin
                  fill_d = fill_q + FW'(1);
                end
              end else begin
                state_d = sle_pkg::S_SFETCH;
              end
            end
          end
        endcase
      end

      sle_pkg::S_EMIT: begin
        if (out_free) begin
          load      = 1'b1;
          load_byte = sle_pkg::const_byte(mode_q, k_q, ch_q);
          load_txv  = (mode_q != sle_pkg::M_NONE);
          k_d       = k_q + 3'd1;
          unique case (mode_q)
            sle_pkg::M_ECHO_CLR: load_last = (k_q == 3'd3);
            sle_pkg::M_PROMPT:   load_last = (k_q == 3'd6) && (hlen_q == '0);
            default:             load_last = 1'b1;
          endcase
          if (load_last) begin
            state_d = sle_pkg::S_IDLE;
          end else if (mode_q == sle_pkg::M_PROMPT && k_q == 3'd6) begin
            state_d = sle_pkg::S_HFETCH;
          end
        end
      end

      sle_pkg::S_HFETCH: begin
        state_d = sle_pkg::S_HPUT;
      end

      sle_pkg::S_HPUT: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = hist_rd_q;
          load_txv   = 1'b1;
          load_last  = (cnt_q == hlen_q - LAw'(1));
          line_we    = 1'b1;
          line_waddr = cnt_q;
          line_wdata = hist_rd_q;
          cnt_d      = cnt_q + LAw'(1);
          state_d    = load_last ? sle_pkg::S_IDLE : sle_pkg::S_HFETCH;
        end
      end

      sle_pkg::S_SFETCH: begin
        state_d = sle_pkg::S_SWRITE;
      end

      sle_pkg::S_SWRITE: begin
        hist_we = 1'b1;
        cnt_d   = cnt_q + LAw'(1);
        if (cnt_q == rlen_q - LAw'(1)) begin
          hlen_we = 1'b1;
          head_d  = head_q + HAw'(1);
          if (fill_q != sle_pkg::FillMax) begin
            fill_d = fill_q + FW'(1);
          end
          mode_d  = sle_pkg::M_NONE;
          k_d     = '0;
          state_d = sle_pkg::S_EMIT;
        end else begin
          state_d = sle_pkg::S_SFETCH;
        end
      end

      default: state_d = sle_pkg::S_IDLE;
    endcase
  end

  // Status fields show the state after the step, which is already settled
  // by the time any byte is loaded.
  always_comb begin
    ov_d = ov_q;
    od_d = od_q;
    ol_d = ol_q;
    if (m_axis_tready) begin
      ov_d = 1'b0;
    end
    if (load) begin
      ov_d = 1'b1;
      od_d = {ovf_q, pend_q, (pend_q ? rlen_q : LAw'(0)), rd_q, load_txv,
              (load_txv ? load_byte : 8'h00)};
      ol_d = load_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sle_pkg::S_IDLE;
      mode_q  <= sle_pkg::M_NONE;
      echo_q  <= 1'b1;
      up_q    <= 8'd65;
      down_q  <= 8'd66;
      esc_q   <= sle_pkg::EscIdle;
      lc_q    <= '0;
      rlen_q  <= '0;
      pend_q  <= 1'b0;
      ovf_q   <= 1'b0;
      head_q  <= '0;
      cur_q   <= '0;
      curv_q  <= 1'b0;
      fill_q  <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      echo_q  <= echo_d;
      up_q    <= up_d;
      down_q  <= down_d;
      esc_q   <= esc_d;
      lc_q    <= lc_d;
      rlen_q  <= rlen_d;
      pend_q  <= pend_d;
      ovf_q   <= ovf_d;
      head_q  <= head_d;
      cur_q   <= cur_d;
      curv_q  <= curv_d;
      fill_q  <= fill_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    ch_q   <= ch_d;
    idx_q  <= idx_d;
    rd_q   <= rd_d;
    hlen_q <= hlen_d;
    slot_q <= slot_d;
    od_q   <= od_d;
    ol_q   <= ol_d;
  end

  a_hput_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sle_pkg::S_HPUT) |-> (cnt_q < hlen_q))
    else $error("history byte index beyond recalled length");

  a_cursor_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    curv_q |-> ({1'b0, cur_q} < fill_q))
    else $error("history cursor beyond filled entries");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= sle_pkg::FillMax)
    else $error("history fill count overrun");

  a_pending_from_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> $past(state_q == sle_pkg::S_DECODE))
    else $error("line became pending outside decode");

endmodule
